>>> sv/pke_pkg.sv
// ----------------------------------------------------------------------------
// pke_pkg
// Types and constants shared by the PSSH key ID extractor and its checker.
// ----------------------------------------------------------------------------
package pke_pkg;

  localparam int unsigned KEY_ID_BYTES    = 16;
  localparam int unsigned SYSTEM_ID_BYTES = 16;
  localparam int unsigned HEADER_BYTES    = 12 + SYSTEM_ID_BYTES;

  // 'pssh' box type, first byte on the wire at index 0
  localparam logic [0:3][7:0] BOX_TYPE = {8'h70, 8'h73, 8'h73, 8'h68};

  // common system ID, first byte on the wire at index 0
  localparam logic [0:SYSTEM_ID_BYTES-1][7:0] COMMON_SYSTEM_ID = {
    8'h10, 8'h77, 8'hef, 8'hec, 8'hc0, 8'hb2, 8'h4d, 8'h02,
    8'hac, 8'he3, 8'h3c, 8'h1e, 8'h52, 8'he2, 8'hfb, 8'h4b};

  typedef enum logic [3:0] {
    PH_SIZE,
    PH_TYPE,
    PH_VER,
    PH_SYSID,
    PH_COUNT,
    PH_KEYS,
    PH_SKIP,
    PH_SKIPALL
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_PSSH  = 3'd1,
    ST_TRUNC     = 3'd2,
    ST_VER0      = 3'd3,
    ST_NO_COMMON = 3'd4
  } status_e;

  typedef enum logic {
    KIND_KEY    = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] init_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  key_byte;
    logic [31:0] key_number;
    logic [3:0]  byte_in_key;
    logic [2:0]  status;
    logic        last;
  } out_t;

endpackage

>>> sv/pssh_key_id_extractor.sv
// ----------------------------------------------------------------------------
// pssh_key_id_extractor
// Streaming CENC pssh parser: walks boxes byte by byte, skips foreign
// systems, streams key ID bytes of the first common box, ends with a status.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------
//  in      | input     | in_valid_i / in_stall_o  | pke_pkg::in_t
//  out     | output    | out_valid_o / out_stall_i| pke_pkg::out_t
//
//  One init byte is parsed in the cycle it is accepted; its results land in a
//  4-entry result queue and are visible on the next cycle.
//  A byte yields at most two results (key byte, then status), so a byte that
//  closes a key run pushes two queue entries.
//  in_stall_o rises while the queue holds three or more entries; it depends
//  on registers only.
//  Asynchronous active-low reset returns the parser to the box size field
//  and empties the queue.
// ----------------------------------------------------------------------------
module pssh_key_id_extractor (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pke_pkg::in_t   in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pke_pkg::out_t  out_o
);
  import pke_pkg::*;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  phase_e      phase_q, phase_d;
  logic [4:0]  fc_q, fc_d;
  logic [31:0] len_q, len_d;
  logic [7:0]  ver_q, ver_d;
  logic        match_q, match_d;
  logic [31:0] total_q, total_d;
  logic [31:0] done_q, done_d;
  logic [31:0] skip_q, skip_d;
  logic        fin_q, fin_d;

  logic        accept;
  logic [7:0]  b;
  logic        lastb;
  logic        key_v, st_v, clear;
  status_e     st_code;
  logic        m;
  logic [31:0] cnt_new, skip_new, done_new;
  logic [4:0]  fc_inc;

  assign accept = in_valid_i && !in_stall_o;
  assign b      = in_i.init_byte;
  assign lastb  = in_i.last_byte;
  assign fc_inc = fc_q + 5'd1;

  always_comb begin
    phase_d  = phase_q;
    fc_d     = fc_q;
    len_d    = len_q;
    ver_d    = ver_q;
    match_d  = match_q;
    total_d  = total_q;
    done_d   = done_q;
    skip_d   = skip_q;
    fin_d    = fin_q;
    key_v    = 1'b0;
    st_v     = 1'b0;
    st_code  = ST_OK;
    clear    = 1'b0;
    m        = 1'b0;
    cnt_new  = {total_q[23:0], b};
    skip_new = (skip_q != 32'd0) ? skip_q - 32'd1 : skip_q;
    done_new = done_q + 32'd1;

    if (accept) begin
      if (fin_q) begin
        clear = lastb;
      end else begin
        case (phase_q)
          PH_SIZE: begin
            len_d = (fc_q == 5'd0) ? {24'd0, b} : {len_q[23:0], b};
            fc_d  = fc_inc;
            if (fc_q == 5'd3) begin
              phase_d = PH_TYPE;
              fc_d    = 5'd0;
              match_d = 1'b1;
            end
            if (lastb) begin
              st_v = 1'b1; st_code = ST_NOT_PSSH;
            end
          end
          PH_TYPE: begin
            m       = match_q && (b == BOX_TYPE[fc_q[1:0]]);
            match_d = m;
            fc_d    = fc_inc;
            if (fc_q == 5'd3) begin
              if (!m) begin
                st_v = 1'b1; st_code = ST_NOT_PSSH;
              end else begin
                phase_d = PH_VER;
                fc_d    = 5'd0;
                if (lastb) begin
                  st_v = 1'b1; st_code = ST_TRUNC;
                end
              end
            end else if (lastb) begin
              st_v = 1'b1; st_code = ST_NOT_PSSH;
            end
          end
          PH_VER: begin
            if (fc_q == 5'd0) ver_d = b;
            fc_d = fc_inc;
            if (fc_q == 5'd3) begin
              phase_d = PH_SYSID;
              fc_d    = 5'd0;
              match_d = 1'b1;
            end
            if (lastb) begin
              st_v = 1'b1; st_code = ST_TRUNC;
            end
          end
          PH_SYSID: begin
            m       = match_q && !fc_q[4] && (b == COMMON_SYSTEM_ID[fc_q[3:0]]);
            match_d = m;
            fc_d    = fc_inc;
            if (fc_q == 5'(SYSTEM_ID_BYTES - 1)) begin
              fc_d = 5'd0;
              if (!m) begin
                // foreign system: skip the rest of the box by its size, or all input if size < header
                if (len_q >= 32'(HEADER_BYTES)) begin
                  skip_d  = len_q - 32'(HEADER_BYTES);
                  phase_d = (len_q == 32'(HEADER_BYTES)) ? PH_SIZE : PH_SKIP;
                end else begin
                  phase_d = PH_SKIPALL;
                end
                if (lastb) begin
                  st_v = 1'b1; st_code = ST_NO_COMMON;
                end
              end else if (ver_q == 8'd0) begin
                st_v = 1'b1; st_code = ST_VER0;
              end else begin
                phase_d = PH_COUNT;
                total_d = 32'd0;
                if (lastb) begin
                  st_v = 1'b1; st_code = ST_TRUNC;
                end
              end
            end else if (lastb) begin
              st_v = 1'b1; st_code = ST_TRUNC;
            end
          end
          PH_COUNT: begin
            total_d = cnt_new;
            fc_d    = fc_inc;
            if (fc_q == 5'd3) begin
              fc_d   = 5'd0;
              done_d = 32'd0;
              if (cnt_new == 32'd0) begin
                st_v = 1'b1; st_code = ST_OK;
              end else begin
                phase_d = PH_KEYS;
                if (lastb) begin
                  st_v = 1'b1; st_code = ST_TRUNC;
                end
              end
            end else if (lastb) begin
              st_v = 1'b1; st_code = ST_TRUNC;
            end
          end
          PH_KEYS: begin
            key_v = 1'b1;
            fc_d  = fc_inc;
            if (fc_q == 5'(KEY_ID_BYTES - 1)) begin
              fc_d   = 5'd0;
              done_d = done_new;
              if (done_new == total_q) begin
                st_v = 1'b1; st_code = ST_OK;
              end else if (lastb) begin
                st_v = 1'b1; st_code = ST_TRUNC;
              end
            end else if (lastb) begin
              st_v = 1'b1; st_code = ST_TRUNC;
            end
          end
          PH_SKIP: begin
            skip_d = skip_new;
            if (skip_new == 32'd0) begin
              phase_d = PH_SIZE;
              fc_d    = 5'd0;
            end
            if (lastb) begin
              st_v = 1'b1; st_code = ST_NO_COMMON;
            end
          end
          default: begin
            if (lastb) begin
              st_v = 1'b1; st_code = ST_NO_COMMON;
            end
          end
        endcase
        // a status closes the run; the last byte restarts it
        if (st_v) begin
          if (lastb) clear = 1'b1;
          else fin_d = 1'b1;
        end
      end
    end

    if (clear) begin
      phase_d = PH_SIZE;
      fc_d    = 5'd0;
      len_d   = 32'd0;
      ver_d   = 8'd0;
      match_d = 1'b1;
      total_d = 32'd0;
      done_d  = 32'd0;
      skip_d  = 32'd0;
      fin_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIZE;
      fc_q    <= 5'd0;
      len_q   <= 32'd0;
      ver_q   <= 8'd0;
      match_q <= 1'b1;
      total_q <= 32'd0;
      done_q  <= 32'd0;
      skip_q  <= 32'd0;
      fin_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fc_q    <= fc_d;
      len_q   <= len_d;
      ver_q   <= ver_d;
      match_q <= match_d;
      total_q <= total_d;
      done_q  <= done_d;
      skip_q  <= skip_d;
      fin_q   <= fin_d;
    end
  end

  // ---------------- result queue ----------------
  out_t            q_mem [QDepth];
  logic [QAw-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QAw:0]    cnt_q, cnt_d;
  out_t            key_res, st_res, wr0, wr1;
  logic            push0, push1, pop;

  always_comb begin
    key_res             = '0;
    key_res.kind        = KIND_KEY;
    key_res.key_byte    = b;
    key_res.key_number  = done_q;
    key_res.byte_in_key = fc_q[3:0];
    key_res.status      = ST_OK;
    key_res.last        = 1'b0;

    st_res        = '0;
    st_res.kind   = KIND_STATUS;
    st_res.status = st_code;
    st_res.last   = 1'b1;

    push0 = key_v || st_v;
    push1 = key_v && st_v;
    wr0   = key_v ? key_res : st_res;
    wr1   = st_res;
  end

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_o       = q_mem[rd_q];
  assign in_stall_o  = (cnt_q > (QAw+1)'(QDepth - 2));

  always_comb begin
    wr_d  = wr_q + QAw'(push0) + QAw'(push1);
    rd_d  = rd_q + QAw'(pop);
    cnt_d = cnt_q + (QAw+1)'(push0) + (QAw+1)'(push1) - (QAw+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0) q_mem[wr_q] <= wr0;
    if (push1) q_mem[wr_q + QAw'(1)] <= wr1;
  end

endmodule

>>> sv/pke_checker.sv
// ----------------------------------------------------------------------------
// pke_checker
// Port-level checks for the PSSH key ID extractor, bound into the extractor module.
// ----------------------------------------------------------------------------
module pke_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input pke_pkg::in_t   in_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input pke_pkg::out_t  out_o
);
  import pke_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

  // an empty result side never back-pressures the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with no pending result");

  // key bytes never carry the run end or a status
  a_key_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.kind == KIND_KEY) |->
      !out_o.last && (out_o.status == ST_OK))
    else $error("malformed key byte result");

  // status results are clean and in range
  a_status_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.kind == KIND_STATUS) |->
      out_o.last && (out_o.key_byte == 8'd0) && (out_o.key_number == 32'd0) &&
      (out_o.byte_in_key == 4'd0) && (out_o.status <= ST_NO_COMMON))
    else $error("malformed status result");

endmodule

bind pssh_key_id_extractor pke_checker u_pke_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);
